### src/wvr_pkg.sv
// package for the wormhole vc mesh router: sizes, codes, flit and word types
// no dependencies
package wvr_pkg;
   localparam int NumVcs = 2;
   localparam int BufferDepth = 4;
   localparam int PayloadBits = 32;
   localparam int NumPorts = 5;
   localparam int NumSlots = NumPorts * NumVcs;
   localparam int SlotBits = $clog2(NumSlots);
   localparam int PtrBits = (BufferDepth > 1) ? $clog2(BufferDepth) : 1;
   localparam int FillBits = $clog2(BufferDepth + 1);
   localparam int MemDepth = NumSlots * BufferDepth;
   localparam int MemAddrBits = $clog2(MemDepth);
   localparam logic [2:0] PortLocal = 3'd4;
   localparam logic [5:0] CreditMax = 6'd63;

   typedef enum logic [1:0] {
      OP_TICK = 2'd0, OP_ACCEPT = 2'd1, OP_CREDIT = 2'd2, OP_SET = 2'd3
   } op_type;

   localparam logic [1:0] FlitHead = 2'd0;
   localparam logic [1:0] FlitBody = 2'd1;
   localparam logic [1:0] FlitTail = 2'd2;
   localparam logic [1:0] FlitSingle = 2'd3;

   typedef struct packed {
      logic [1:0]  flit_type;
      logic [3:0]  dest_row;
      logic [3:0]  dest_col;
      logic [31:0] payload;
   } flit_type_s_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [2:0]  port_dir;
      logic [2:0]  vc;
      logic [1:0]  flit_type;
      logic [3:0]  dest_row;
      logic [3:0]  dest_col;
      logic [31:0] payload;
      logic [5:0]  credit_count;
   } req_word_type;

   typedef struct packed {
      logic        kind;
      logic        accepted;
      logic [2:0]  out_dir;
      logic [2:0]  out_vc;
      logic [1:0]  out_flit_type;
      logic [3:0]  out_dest_row;
      logic [3:0]  out_dest_col;
      logic [31:0] out_payload;
      logic        last;
   } rsp_word_type;
endpackage

### src/wvr_stream_if.sv
// valid/ready channel carrying one word of a given type
// no dependencies; the word type is a parameter
interface wvr_stream_if #(parameter type word_type = logic) ();
   logic     valid;
   logic     ready;
   word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### src/wvr_flit_ram.sv
// flit buffer memory, one write and one registered read port
// depends on wvr_pkg
module wvr_flit_ram (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [wvr_pkg::MemAddrBits-1:0] wr_addr,
   input  wvr_pkg::flit_type_s_type    wr_data,
   input  logic [wvr_pkg::MemAddrBits-1:0] rd_addr,
   output wvr_pkg::flit_type_s_type    rd_data
);
   import wvr_pkg::*;
   flit_type_s_type mem [MemDepth];

   // synchronous write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

### src/wormhole_vc_mesh_router_core.sv
// five-port wormhole vc router top level: control, state, allocation
// depends on wvr_pkg, wvr_stream_if and wvr_flit_ram
//
// usage
//   req channel carries one word per operation: enqueue a flit, return a
//   credit, set a credit count, or a router tick. rsp channel carries the
//   results: one accept response per enqueue, and up to five forwarded
//   flits per tick in output order (north, east, south, west, local), the
//   final one flagged by last. credit ops and idle ticks give no word.
//   csr port (apb style) holds my_row at 0x0 and my_col at 0x4.
// sequencing
//   one operation at a time. credit ops and enqueues are captured, then
//   executed. a tick is captured, then routes every slot in turn (one flit
//   ram read per slot), then per output port scans and, with a winner,
//   reads, emits and advances, then closes; the single read port of the
//   flit ram sets this order.
// reset
//   synchronous active-high reset clears fifo pointers, routes, locks,
//   credits and round-robin pointers; flit contents stay undefined.
// stall
//   while rsp_ready is low the pending word holds and no new word enters.
module wormhole_vc_mesh_router_core (
   input  logic        clock,
   input  logic        reset,
   wvr_stream_if.sink   req,
   wvr_stream_if.source rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import wvr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_EXEC, ST_ROUTE, ST_SCAN, ST_READ, ST_EMIT, ST_OUT
   } state_type;

   state_type state_ff;
   req_word_type req_ff;
   logic [3:0] my_row_ff, my_col_ff;
   logic [PtrBits-1:0] head_ff [NumSlots];
   logic [FillBits-1:0] fill_ff [NumSlots];
   logic [NumSlots-1:0] rvalid_ff, lock_ff;
   logic [2:0] rport_ff [NumSlots];
   logic [2:0] lport_ff [NumSlots];
   logic [5:0] credit_ff [NumSlots];
   logic [SlotBits-1:0] rr_ff [NumPorts];
   logic [2:0] od_ff;
   logic [SlotBits-1:0] best_ff;
   logic route_idx_valid_ff;
   logic [SlotBits-1:0] ridx_ff;
   logic have_ff;
   rsp_word_type stage_ff;
   rsp_word_type hold_ff;
   logic hold_valid_ff;

   // flit ram
   logic wr_en;
   logic [MemAddrBits-1:0] wr_addr, rd_addr;
   flit_type_s_type wr_data, rd_data;
   wvr_flit_ram u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   // csr
   assign csr_pready = 1'b1;
   always_comb begin
      case (csr_paddr[2])
         1'b0:    csr_prdata = {28'd0, my_row_ff};
         default: csr_prdata = {28'd0, my_col_ff};
      endcase
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         my_row_ff <= '0;
         my_col_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr == 3'd0) my_row_ff <= csr_pwdata[3:0];
         else if (csr_paddr == 3'd4) my_col_ff <= csr_pwdata[3:0];
      end
   end

   // decoded request
   logic ok, acc_ok;
   logic [SlotBits-1:0] slot;
   logic hold_free, load_hold;
   rsp_word_type load_word;
   always_comb begin
      ok = (req_ff.port_dir < 3'(NumPorts)) && (req_ff.vc < 3'(NumVcs));
      slot = ok ? SlotBits'(req_ff.port_dir * NumVcs + req_ff.vc) : '0;
      acc_ok = ok && (fill_ff[slot] < FillBits'(BufferDepth));
   end

   // xy route of the flit just read
   function automatic logic [2:0] xy(input logic [3:0] r, input logic [3:0] c,
                                     input logic [3:0] mr, input logic [3:0] mc);
      logic [2:0] p;
      if (mc < c) p = 3'd1;
      else if (mc > c) p = 3'd3;
      else if (mr < r) p = 3'd2;
      else if (mr > r) p = 3'd0;
      else p = PortLocal;
      return p;
   endfunction

   // round-robin pick for output od_ff
   logic found;
   logic [SlotBits-1:0] pick;
   always_comb begin
      logic [SlotBits:0] cand;
      logic [SlotBits-1:0] s;
      found = 1'b0;
      pick = '0;
      for (int k = 0; k < NumSlots; k++) begin
         cand = (SlotBits+1)'(rr_ff[od_ff]) + (SlotBits+1)'(k);
         if (cand >= (SlotBits+1)'(NumSlots)) cand = cand - (SlotBits+1)'(NumSlots);
         s = cand[SlotBits-1:0];
         if (!found && rvalid_ff[s] && rport_ff[s] == od_ff && fill_ff[s] != '0 &&
             (od_ff == PortLocal ||
              credit_ff[SlotBits'(od_ff * NumVcs) + SlotBits'(s % NumVcs)] != '0)) begin
            found = 1'b1;
            pick = s;
         end
      end
   end

   // output register loading: accept response, staged flit, or final flit
   always_comb begin
      hold_free = !hold_valid_ff || rsp.ready;
      load_hold = 1'b0;
      load_word = stage_ff;
      case (state_ff)
         ST_EXEC: begin
            if (req_ff.opcode == OP_ACCEPT && hold_free) begin
               load_hold = 1'b1;
               load_word = '{1'b0, acc_ok, 3'd0, 3'd0, 2'd0, 4'd0, 4'd0, 32'd0, 1'b1};
            end
         end
         ST_EMIT: load_hold = have_ff && hold_free;
         ST_OUT: begin
            if (od_ff == PortLocal && have_ff && hold_free) begin
               load_hold = 1'b1;
               load_word.last = 1'b1;
            end
         end
         default: load_hold = 1'b0;
      endcase
   end

   // memory addressing
   always_comb begin
      logic [PtrBits:0] tail;
      tail = (PtrBits+1)'(head_ff[slot]) + (PtrBits+1)'(fill_ff[slot]);
      if (tail >= (PtrBits+1)'(BufferDepth)) tail = tail - (PtrBits+1)'(BufferDepth);
      wr_en = (state_ff == ST_EXEC) && (req_ff.opcode == OP_ACCEPT) && acc_ok &&
              hold_free;
      wr_addr = MemAddrBits'(slot * BufferDepth) + MemAddrBits'(tail[PtrBits-1:0]);
      wr_data = '{req_ff.flit_type, req_ff.dest_row, req_ff.dest_col,
                  32'(PayloadBits'(req_ff.payload))};
      case (state_ff)
         ST_ROUTE: rd_addr = MemAddrBits'(ridx_ff * BufferDepth) +
                             MemAddrBits'(head_ff[ridx_ff]);
         default:  rd_addr = MemAddrBits'(best_ff * BufferDepth) +
                             MemAddrBits'(head_ff[best_ff]);
      endcase
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = hold_valid_ff;
   assign rsp.data = hold_ff;

   // control sequencer with all router state but the csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         hold_valid_ff <= 1'b0;
         rvalid_ff <= '0;
         lock_ff <= '0;
         route_idx_valid_ff <= 1'b0;
         have_ff <= 1'b0;
         od_ff <= '0;
         ridx_ff <= '0;
         best_ff <= '0;
         for (int i = 0; i < NumSlots; i++) begin
            head_ff[i] <= '0;
            fill_ff[i] <= '0;
            rport_ff[i] <= '0;
            lport_ff[i] <= '0;
            credit_ff[i] <= '0;
         end
         for (int i = 0; i < NumPorts; i++) rr_ff[i] <= '0;
      end else begin
         if (load_hold) begin
            hold_ff <= load_word;
            hold_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            hold_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req.valid) begin
                  req_ff <= req.data;
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               case (req_ff.opcode)
                  OP_ACCEPT: begin
                     if (hold_free) begin
                        if (acc_ok) fill_ff[slot] <= fill_ff[slot] + 1'b1;
                        state_ff <= ST_IDLE;
                     end
                  end
                  OP_CREDIT: begin
                     if (ok && credit_ff[slot] < CreditMax)
                        credit_ff[slot] <= credit_ff[slot] + 1'b1;
                     state_ff <= ST_IDLE;
                  end
                  OP_SET: begin
                     if (ok) credit_ff[slot] <= req_ff.credit_count;
                     state_ff <= ST_IDLE;
                  end
                  default: begin
                     ridx_ff <= '0;
                     route_idx_valid_ff <= 1'b0;
                     state_ff <= ST_ROUTE;
                  end
               endcase
            end
            // one slot per cycle: read head flit, compute route next cycle
            ST_ROUTE: begin
               if (route_idx_valid_ff) begin
                  if (fill_ff[best_ff] != '0) begin
                     if (lock_ff[best_ff]) begin
                        rvalid_ff[best_ff] <= 1'b1;
                        rport_ff[best_ff] <= lport_ff[best_ff];
                     end else if (rd_data.flit_type == FlitHead ||
                                  rd_data.flit_type == FlitSingle) begin
                        rvalid_ff[best_ff] <= 1'b1;
                        rport_ff[best_ff] <= xy(rd_data.dest_row, rd_data.dest_col,
                                                my_row_ff, my_col_ff);
                     end
                  end
               end
               best_ff <= ridx_ff;
               if (route_idx_valid_ff && best_ff == SlotBits'(NumSlots - 1)) begin
                  route_idx_valid_ff <= 1'b0;
                  od_ff <= '0;
                  have_ff <= 1'b0;
                  state_ff <= ST_SCAN;
               end else begin
                  route_idx_valid_ff <= 1'b1;
                  if (ridx_ff != SlotBits'(NumSlots - 1)) ridx_ff <= ridx_ff + 1'b1;
               end
            end
            ST_SCAN: begin
               if (found) begin
                  best_ff <= pick;
                  state_ff <= ST_READ;
               end else if (od_ff == PortLocal) begin
                  state_ff <= ST_OUT;
               end else begin
                  od_ff <= od_ff + 1'b1;
               end
            end
            ST_READ: state_ff <= ST_EMIT;
            // update state for winner, stage word (previous one goes out first)
            ST_EMIT: begin
               if (!have_ff || hold_free) begin
                  stage_ff <= '{1'b1, 1'b0, od_ff, 3'(best_ff % NumVcs), rd_data.flit_type,
                                rd_data.dest_row, rd_data.dest_col, rd_data.payload, 1'b0};
                  have_ff <= 1'b1;
                  state_ff <= ST_OUT;
                  head_ff[best_ff] <= (head_ff[best_ff] == PtrBits'(BufferDepth - 1)) ?
                                      '0 : head_ff[best_ff] + 1'b1;
                  fill_ff[best_ff] <= fill_ff[best_ff] - 1'b1;
                  if (rd_data.flit_type == FlitHead) begin
                     lock_ff[best_ff] <= 1'b1;
                     lport_ff[best_ff] <= od_ff;
                  end else if (rd_data.flit_type == FlitTail ||
                               rd_data.flit_type == FlitSingle) begin
                     lock_ff[best_ff] <= 1'b0;
                     rvalid_ff[best_ff] <= 1'b0;
                  end else if (!lock_ff[best_ff]) begin
                     rvalid_ff[best_ff] <= 1'b0;
                  end
                  if (od_ff != PortLocal) begin
                     if (credit_ff[SlotBits'(od_ff * NumVcs) + SlotBits'(best_ff % NumVcs)]
                         != '0)
                        credit_ff[SlotBits'(od_ff * NumVcs) + SlotBits'(best_ff % NumVcs)] <=
                           credit_ff[SlotBits'(od_ff * NumVcs) +
                                     SlotBits'(best_ff % NumVcs)] - 1'b1;
                  end
                  rr_ff[od_ff] <= (best_ff == SlotBits'(NumSlots - 1)) ?
                                  '0 : best_ff + 1'b1;
               end
            end
            // move on to next output, or flush the staged word with last
            ST_OUT: begin
               if (od_ff != PortLocal) begin
                  od_ff <= od_ff + 1'b1;
                  state_ff <= ST_SCAN;
               end else if (!have_ff) begin
                  state_ff <= ST_IDLE;
               end else if (hold_free) begin
                  have_ff <= 1'b0;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

### sim/wvr_route_checker.sv
// router result checker: predicts forwarded flits and accept responses
// depends on wvr_pkg; watches req and rsp, counts failures
`timescale 1ns / 1ps
module wvr_route_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  wvr_pkg::req_word_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  wvr_pkg::rsp_word_type rsp_data,
   input  logic         cfg_we,
   input  logic         cfg_sel,
   input  logic [3:0]   cfg_value,
   output int           fail_count,
   output int           pending_words,
   output int           flits_seen
);
   import wvr_pkg::*;

   localparam int ExpDepth = 256;

   flit_type_s_type  vc_buf [NumSlots][BufferDepth];
   int unsigned      buf_head [NumSlots];
   int unsigned      buf_fill [NumSlots];
   bit               has_route [NumSlots];
   logic [2:0]       route_to [NumSlots];
   bit               locked [NumSlots];
   logic [2:0]       locked_to [NumSlots];
   int unsigned      credits [NumSlots];
   int unsigned      rr_next [NumPorts];
   logic [3:0]       row_reg, col_reg;
   rsp_word_type     expected_words [ExpDepth];
   int unsigned      exp_rd, exp_wr;

   assign pending_words = int'(exp_wr - exp_rd);

   // add one word to the expected list
   task automatic exp_put(rsp_word_type w);
      expected_words[exp_wr % ExpDepth] = w;
      exp_wr++;
   endtask

   // dimension-ordered route, column first
   function automatic logic [2:0] xy_port(logic [3:0] r, logic [3:0] c);
      if (col_reg < c) return 3'd1;
      if (col_reg > c) return 3'd3;
      if (row_reg < r) return 3'd2;
      if (row_reg > r) return 3'd0;
      return PortLocal;
   endfunction

   // one router tick: route compute then per-output allocation
   task automatic run_tick();
      rsp_word_type    w;
      flit_type_s_type f;
      int unsigned     best, bestd, gap_len, pr, v, n_out;
      bit              found;
      n_out = 0;
      for (int s = 0; s < NumSlots; s++) begin
         if (buf_fill[s] == 0) continue;
         f = vc_buf[s][buf_head[s]];
         if (locked[s]) begin
            has_route[s] = 1; route_to[s] = locked_to[s];
         end else if (f.flit_type == FlitHead || f.flit_type == FlitSingle) begin
            has_route[s] = 1; route_to[s] = xy_port(f.dest_row, f.dest_col);
         end
      end
      for (int od = 0; od < NumPorts; od++) begin
         found = 0; bestd = '1; best = 0; pr = rr_next[od];
         for (int s = 0; s < NumSlots; s++) begin
            v = s % NumVcs;
            if (!has_route[s] || route_to[s] != od || buf_fill[s] == 0) continue;
            if (od != PortLocal && credits[od*NumVcs+v] == 0) continue;
            gap_len = (s >= pr) ? s - pr : s + NumSlots - pr;
            if (gap_len < bestd) begin
               bestd = gap_len; best = s; found = 1;
            end
         end
         if (!found) continue;
         f = vc_buf[best][buf_head[best]];
         buf_head[best] = (buf_head[best] + 1) % BufferDepth;
         buf_fill[best]--;
         if (f.flit_type == FlitHead) begin
            locked[best] = 1; locked_to[best] = 3'(od);
         end else begin
            if (f.flit_type == FlitTail || f.flit_type == FlitSingle) locked[best] = 0;
            if (!locked[best]) has_route[best] = 0;
         end
         if (od != PortLocal && credits[od*NumVcs + best%NumVcs] > 0)
            credits[od*NumVcs + best%NumVcs]--;
         rr_next[od] = (best + 1) % NumSlots;
         w = '0;
         w.kind = 1; w.out_dir = 3'(od); w.out_vc = 3'(best % NumVcs);
         w.out_flit_type = f.flit_type; w.out_dest_row = f.dest_row;
         w.out_dest_col = f.dest_col; w.out_payload = f.payload;
         exp_put(w);
         n_out++;
      end
      if (n_out > 0)
         expected_words[(exp_wr - 1) % ExpDepth].last = 1;
   endtask

   task automatic predict_word(req_word_type q);
      rsp_word_type w;
      int unsigned  s;
      bit           ok;
      ok = q.port_dir < NumPorts && q.vc < NumVcs;
      s = ok ? q.port_dir * NumVcs + q.vc : 0;
      case (op_type'(q.opcode))
         OP_TICK: run_tick();
         OP_ACCEPT: begin
            w = '0; w.last = 1;
            if (ok && buf_fill[s] < BufferDepth) begin
               vc_buf[s][(buf_head[s] + buf_fill[s]) % BufferDepth] =
                  '{q.flit_type, q.dest_row, q.dest_col, q.payload};
               buf_fill[s]++;
               w.accepted = 1;
            end
            exp_put(w);
         end
         OP_CREDIT: if (ok && credits[s] < CreditMax) credits[s]++;
         OP_SET: if (ok) credits[s] = 32'(q.credit_count);
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      rsp_word_type e;
      if (reset) begin
         exp_rd = 0; exp_wr = 0;
         for (int s = 0; s < NumSlots; s++) begin
            buf_head[s] = 0; buf_fill[s] = 0; has_route[s] = 0; route_to[s] = 0;
            locked[s] = 0; locked_to[s] = 0; credits[s] = 0;
         end
         for (int p = 0; p < NumPorts; p++) rr_next[p] = 0;
         row_reg = 0; col_reg = 0;
         fail_count = 0; flits_seen = 0;
      end else begin
         if (cfg_we) begin
            if (cfg_sel) col_reg = cfg_value;
            else row_reg = cfg_value;
         end
         // compare before predicting, results trail their request
         if (rsp_valid && rsp_ready) begin
            if (exp_wr == exp_rd) begin
               $display("%0t: unexpected word %p", $time, rsp_data);
               fail_count++;
            end else begin
               e = expected_words[exp_rd % ExpDepth];
               exp_rd++;
               if (e.kind) flits_seen++;
               if (rsp_data !== e) begin
                  $display("%0t: mismatch expected %p actual %p", $time, e, rsp_data);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) predict_word(req_data);
      end
   end
endmodule

### sim/wormhole_vc_mesh_router_core_tb.sv
// testbench top for the wormhole vc router: clock, reset, stimulus, verdict
// depends on wvr_pkg, wvr_stream_if, the router core and wvr_route_checker
`timescale 1ns / 1ps
module wormhole_vc_mesh_router_core_tb;
   import wvr_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [2:0]  csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count, pending_words, flits_seen;
   int          req_count = 0;

   wvr_stream_if #(.word_type(req_word_type)) req_if ();
   wvr_stream_if #(.word_type(rsp_word_type)) rsp_if ();

   initial begin
      req_if.valid = 0;
      req_if.data = '0;
      rsp_if.ready = 0;
   end

   always #5 clock = ~clock;

   wormhole_vc_mesh_router_core dut (
      .clock(clock), .reset(reset), .req(req_if.sink), .rsp(rsp_if.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready));

   wvr_route_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_if.valid), .req_ready(req_if.ready), .req_data(req_if.data),
      .rsp_valid(rsp_if.valid), .rsp_ready(rsp_if.ready), .rsp_data(rsp_if.data),
      .cfg_we(csr_psel && csr_penable && csr_pwrite && csr_pready),
      .cfg_sel(csr_paddr[2]), .cfg_value(csr_pwdata[3:0]),
      .fail_count(fail_count), .pending_words(pending_words),
      .flits_seen(flits_seen));

   // receiver stalls drawn per word, with quiet stretches of none
   initial begin
      int gap;
      @(posedge clock iff !reset);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
         if (gap > 0) begin
            rsp_if.ready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1;
         @(posedge clock iff rsp_if.valid);
      end
   end

   // valid stays up after acceptance until the next word or an idle gap
   task automatic send_word(req_word_type w, bit no_gap = 0);
      int gap;
      gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_if.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_if.data <= w;
      req_if.valid <= 1;
      @(posedge clock iff req_if.ready);
      req_count++;
   endtask

   task automatic req_stop();
      req_if.valid <= 0;
   endtask

   function automatic req_word_type make_op(op_type op, int port, int vc,
                                            logic [1:0] ft = FlitSingle,
                                            logic [3:0] dr = 0, logic [3:0] dc = 0,
                                            logic [31:0] pl = 0, logic [5:0] cc = 0);
      req_word_type w;
      w = '{op, port[2:0], vc[2:0], ft, dr, dc, pl, cc};
      return w;
   endfunction

   // wait until nothing is owed plus tail latency before a csr write
   task automatic drain();
      wait (pending_words == 0);
      repeat (30) @(posedge clock);
   endtask

   task automatic csr_write(int idx, logic [3:0] value);
      csr_psel <= 1; csr_pwrite <= 1; csr_paddr <= 3'(idx * 4);
      csr_pwdata <= 32'(value);
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      @(posedge clock);
   endtask

   // random word: any op with a random flit type, mostly valid port and vc, some out of range
   task automatic random_word();
      int op, p, v;
      req_word_type w;
      op = $urandom_range(0, 9);
      p = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
      v = ($urandom_range(0, 15) == 0) ? $urandom_range(2, 7) : $urandom_range(0, 1);
      w = make_op(OP_ACCEPT, p, v, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                  4'($urandom_range(0, 15)), $urandom(), 6'($urandom_range(0, 63)));
      if (op < 4) w.opcode = OP_TICK;
      else if (op < 7) w.opcode = OP_ACCEPT;
      else if (op < 9) w.opcode = OP_CREDIT;
      else w.opcode = OP_SET;
      send_word(w);
   endtask

   task automatic send_packet();
      int p, v, n;
      logic [3:0] r, c;
      p = $urandom_range(0, 4); v = $urandom_range(0, 1);
      r = 4'($urandom_range(0, 15)); c = 4'($urandom_range(0, 15));
      n = $urandom_range(0, 2);
      if ($urandom_range(0, 2) == 0) begin
         send_word(make_op(OP_ACCEPT, p, v, FlitSingle, r, c, $urandom()));
         return;
      end
      send_word(make_op(OP_ACCEPT, p, v, FlitHead, r, c, $urandom()));
      for (int i = 0; i < n; i++)
         send_word(make_op(OP_ACCEPT, p, v, FlitBody, r, c, $urandom()));
      send_word(make_op(OP_ACCEPT, p, v, FlitTail, r, c, $urandom()));
   endtask

   initial begin
      logic [3:0] rows [4] = '{4'd0, 4'd15, 4'd7, 4'd3};
      logic [3:0] cols [4] = '{4'd0, 4'd15, 4'd9, 4'd12};
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes, every op, bad port/vc, saturation, idle tick
      send_word(make_op(OP_TICK, 0, 0));
      send_word(make_op(OP_ACCEPT, 7, 0, FlitSingle, 15, 15, '1));
      send_word(make_op(OP_ACCEPT, 0, 7));
      send_word(make_op(OP_CREDIT, 5, 0));
      send_word(make_op(OP_SET, 0, 3, 0, 0, 0, 0, 6'd63));
      send_word(make_op(OP_SET, 1, 0, 0, 0, 0, 0, 6'd63));
      send_word(make_op(OP_CREDIT, 1, 0));
      send_word(make_op(OP_SET, 2, 1, 0, 0, 0, 0, 6'd1));
      for (int i = 0; i < 5; i++)
         send_word(make_op(OP_ACCEPT, 4, 0, FlitSingle, 15, 15, 32'hFFFF_FFFF));
      send_word(make_op(OP_ACCEPT, 3, 1, FlitBody, 0, 0, 32'h0));
      send_word(make_op(OP_ACCEPT, 0, 1, FlitHead, 0, 0, 32'h1234_5678));
      send_word(make_op(OP_ACCEPT, 0, 1, FlitTail, 0, 0, 32'h8765_4321));
      for (int i = 0; i < 6; i++) send_word(make_op(OP_TICK, 0, 0));
      req_stop();
      // sender holds off until everything owed has come back
      wait (pending_words == 0);
      for (int phase = 0; phase < 4; phase++) begin
         drain();
         csr_write(0, rows[phase]);
         csr_write(1, cols[phase]);
         // give every output credits so flits flow
         for (int s = 0; s < NumSlots; s++)
            send_word(make_op(OP_SET, s / NumVcs, s % NumVcs, 0, 0, 0, 0,
                              6'($urandom_range(1, 63))));
         while (req_count < 50 + (phase + 1) * 65) begin
            if ($urandom_range(0, 1)) send_packet();
            else random_word();
         end
         repeat (12) send_word(make_op(OP_TICK, 0, 0), 1);
         req_stop();
      end
      wait (pending_words == 0);
      repeat (40) @(posedge clock);
      $display("covered %0d requests, %0d forwarded flits over four router positions",
               req_count, flits_seen);
      if (fail_count == 0)
         $display("wormhole_vc_mesh_router_core_tb passed");
      else
         $display("wormhole_vc_mesh_router_core_tb failed");
      $finish;
   end

   initial begin
      #5ms;
      $display("wormhole_vc_mesh_router_core_tb failed");
      $finish;
   end
endmodule

### sim.f
src/wvr_pkg.sv
src/wvr_stream_if.sv
src/wvr_flit_ram.sv
src/wormhole_vc_mesh_router_core.sv
sim/wvr_route_checker.sv
sim/wormhole_vc_mesh_router_core_tb.sv
